// ===== sv/apq_pkg.sv =====
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types and codes for the arrival-ordered process queue.
// ----------------------------------------------------------------------------
package apq_pkg;

   localparam int CMD_W            = 2;
   localparam int STATUS_W         = 2;
   localparam int KEY_W            = 32;
   localparam int PROCESS_HANDLE_W = 16;
   localparam int OCC_W            = 5;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_PUSH   = 2'd1;
   localparam cmd_type CMD_POP    = 2'd2;

   localparam status_type STATUS_DONE  = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   // Control part of the operation wave that travels down the cell row.
   typedef struct packed {
      logic             active;
      logic             is_pop;
      logic             sorted;
      logic             placed;
      logic [KEY_W-1:0] key;
   } wave_type;

endpackage

// ===== sv/apq_cell.sv =====
// ----------------------------------------------------------------------------
// apq_cell
// One slot of the queue. Holds an entry and applies the passing operation
// wave to it, handing the displaced or carried entry to the next slot.
// ----------------------------------------------------------------------------
module apq_cell
   import apq_pkg::*;
#(
   parameter int HANDLE_W = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  wave_type            carry_wave,
   input  logic [HANDLE_W-1:0] carry_handle,
   input  logic [KEY_W-1:0]    nbr_key,
   input  logic [HANDLE_W-1:0] nbr_handle,
   input  logic                nbr_valid,
   output wave_type            pass_wave,
   output logic [HANDLE_W-1:0] pass_handle,
   output logic [KEY_W-1:0]    slot_key,
   output logic [HANDLE_W-1:0] slot_handle,
   output logic                slot_valid
);

   logic [KEY_W-1:0]    key_ff, key_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic                valid_ff, valid_in;
   wave_type            wave_ff, wave_in;
   logic [HANDLE_W-1:0] whandle_ff, whandle_in;
   logic                take;

   // The slot takes the carried word once the insert point is found, when it
   // is empty, or when a sorted insert meets a strictly larger key here.
   assign take = carry_wave.placed || !valid_ff ||
                 (carry_wave.sorted && (key_ff > carry_wave.key));

   always_comb begin
      key_in            = key_ff;
      handle_in         = handle_ff;
      valid_in          = valid_ff;
      wave_in           = carry_wave;
      wave_in.active    = 1'b0;
      whandle_in        = carry_handle;
      if (carry_wave.active) begin
         if (carry_wave.is_pop) begin
            key_in         = nbr_key;
            handle_in      = nbr_handle;
            valid_in       = nbr_valid;
            wave_in.active = nbr_valid;
         end else if (take) begin
            key_in         = carry_wave.key;
            handle_in      = carry_handle;
            valid_in       = 1'b1;
            wave_in.key    = key_ff;
            wave_in.placed = 1'b1;
            wave_in.active = valid_ff;
            whandle_in     = handle_ff;
         end else begin
            wave_in.active = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         wave_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         wave_ff  <= wave_in;
      end
      key_ff     <= key_in;
      handle_ff  <= handle_in;
      whandle_ff <= whandle_in;
   end

   assign pass_wave   = wave_ff;
   assign pass_handle = whandle_ff;
   assign slot_key    = key_ff;
   assign slot_handle = handle_ff;
   assign slot_valid  = valid_ff;

endmodule

// ===== sv/arrival_ordered_process_queue.sv =====
// ----------------------------------------------------------------------------
// arrival_ordered_process_queue
// Bounded queue of (arrival key, process handle) entries built as a row of
// slot cells, with sorted insert, push to tail and pop from head.
// ----------------------------------------------------------------------------
// An operation enters the row at slot 0 and moves one slot per cycle; each
// slot shifts or takes an entry as the wave passes. The response word (status,
// popped entry, occupancy) is registered in the cycle after the request is
// accepted, and the next request is taken once the wave has left the occupied
// slots. A dropped insert, a pop of an empty queue or an unknown command sends
// no wave down the row. The response register lets a new request in while
// a response still waits, as long as the response side takes it in the same
// cycle.
module arrival_ordered_process_queue
   import apq_pkg::*;
#(
   parameter int CAPACITY    = 16,
   parameter int HANDLE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [CMD_W-1:0]            req_cmd,
   input  logic [KEY_W-1:0]            req_arrival_key,
   input  logic [PROCESS_HANDLE_W-1:0] req_process_handle,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [KEY_W-1:0]            rsp_popped_key,
   output logic [PROCESS_HANDLE_W-1:0] rsp_popped_handle,
   output logic [OCC_W-1:0]            rsp_occupancy
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int HW    = (HANDLE_BITS < PROCESS_HANDLE_W) ? HANDLE_BITS
                                                           : PROCESS_HANDLE_W;

   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            busy_ff, busy_load;
   wave_type                    wave0_ff, wave0_in;
   logic [HW-1:0]               whandle0_ff;
   logic                        rsp_valid_ff;
   status_type                  status_ff, status_in;
   logic [KEY_W-1:0]            pkey_ff, pkey_in;
   logic [PROCESS_HANDLE_W-1:0] phandle_ff, phandle_in;
   logic [OCC_W-1:0]            occ_ff;
   logic [CNT_W+OCC_W-1:0]      occ_wide;
   logic                        accept, launch, full, empty;

   wave_type                    wave_chain   [CAPACITY];
   logic [HW-1:0]               handle_chain [CAPACITY];
   logic [KEY_W-1:0]            cell_key     [CAPACITY];
   logic [HW-1:0]               cell_handle  [CAPACITY];
   logic                        cell_valid   [CAPACITY];

   assign accept    = req_valid && req_ready;
   assign req_ready = (busy_ff == '0) && (!rsp_valid_ff || rsp_ready);
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   always_comb begin
      status_in  = STATUS_DONE;
      pkey_in    = '0;
      phandle_in = '0;
      count_in   = count_ff;
      launch     = 1'b0;
      busy_load  = '0;
      unique case (req_cmd)
         CMD_INSERT, CMD_PUSH: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               launch    = 1'b1;
               count_in  = count_ff + 1'b1;
               busy_load = count_ff + 1'b1;
            end
         end
         CMD_POP: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               pkey_in    = cell_key[0];
               phandle_in = PROCESS_HANDLE_W'(cell_handle[0]);
               launch     = 1'b1;
               count_in   = count_ff - 1'b1;
               busy_load  = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign occ_wide = (CNT_W + OCC_W)'(count_in);

   always_comb begin
      wave0_in.active = accept && launch;
      wave0_in.is_pop = (req_cmd == CMD_POP);
      wave0_in.sorted = (req_cmd == CMD_INSERT);
      wave0_in.placed = 1'b0;
      wave0_in.key    = req_arrival_key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= '0;
         wave0_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wave0_ff <= wave0_in;
         if (accept) begin
            count_ff     <= count_in;
            busy_ff      <= busy_load;
            rsp_valid_ff <= 1'b1;
         end else begin
            if (busy_ff != '0) begin
               busy_ff <= busy_ff - 1'b1;
            end
            if (rsp_ready) begin
               rsp_valid_ff <= 1'b0;
            end
         end
      end
      whandle0_ff <= req_process_handle[HW-1:0];
      if (accept) begin
         status_ff  <= status_in;
         pkey_ff    <= pkey_in;
         phandle_ff <= phandle_in;
         occ_ff     <= occ_wide[OCC_W-1:0];
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      wave_type         w_in;
      logic [HW-1:0]    h_in;
      logic [KEY_W-1:0] n_key;
      logic [HW-1:0]    n_handle;
      logic             n_valid;

      if (i == 0) begin : g_first
         assign w_in = wave0_ff;
         assign h_in = whandle0_ff;
      end else begin : g_next
         assign w_in = wave_chain[i-1];
         assign h_in = handle_chain[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign n_key    = '0;
         assign n_handle = '0;
         assign n_valid  = 1'b0;
      end else begin : g_inner
         assign n_key    = cell_key[i+1];
         assign n_handle = cell_handle[i+1];
         assign n_valid  = cell_valid[i+1];
      end

      apq_cell #(
         .HANDLE_W(HW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .carry_wave  (w_in),
         .carry_handle(h_in),
         .nbr_key     (n_key),
         .nbr_handle  (n_handle),
         .nbr_valid   (n_valid),
         .pass_wave   (wave_chain[i]),
         .pass_handle (handle_chain[i]),
         .slot_key    (cell_key[i]),
         .slot_handle (cell_handle[i]),
         .slot_valid  (cell_valid[i])
      );
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_popped_key    = pkey_ff;
   assign rsp_popped_handle = phandle_ff;
   assign rsp_occupancy     = occ_ff;

   // The entry count never passes the number of slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // Once the wave has drained, the head slot holds an entry exactly when
   // the queue is not empty.
   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      (busy_ff == '0 && !wave0_ff.active) |-> (cell_valid[0] == (count_ff != '0)))
      else $error("head slot disagrees with entry count");

   // A wave always stops inside the row.
   a_wave_in_row: assert property (@(posedge clock) disable iff (reset)
      !wave_chain[CAPACITY-1].active)
      else $error("operation wave ran past the last slot");

   // A full report is only given with the queue at capacity.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == STATUS_FULL) |-> full)
      else $error("full status while queue not full");

   // An empty report is only given with nothing queued.
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == STATUS_EMPTY) |-> empty)
      else $error("empty status while queue holds entries");

endmodule

// ===== dv/arrival_ordered_process_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrival_ordered_process_queue_tb
// Self-checking bench for the sorted-insert process queue.
// ----------------------------------------------------------------------------
// A driver sends queue operations from a backlog: a short directed list, then
// random segments that fill the store, drain it or mix both. A shadow copy of
// the store predicts every response word. A monitor compares each response
// with the oldest prediction. Both sides insert random gaps and stalls.
module arrival_ordered_process_queue_tb
   import apq_pkg::*;
();

   localparam int CAPACITY    = 16;
   localparam int HANDLE_BITS = 16;
   localparam int CYCLE_LIMIT = 250000;
   localparam int RANDOM_OPS  = 1000;
   localparam int SETTLE_CYCLES = 40;
   localparam cmd_type CMD_UNUSED = 2'd3;
   localparam logic [PROCESS_HANDLE_W-1:0] HANDLE_MASK =
      PROCESS_HANDLE_W'((64'd1 << HANDLE_BITS) - 1);

   typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} segment_kind_type;

   typedef struct {
      cmd_type                     cmd;
      logic [KEY_W-1:0]            key;
      logic [PROCESS_HANDLE_W-1:0] handle;
      int                          gap;
      bit                          hold_until_drained;
   } queue_op_type;

   typedef struct {
      status_type                  status;
      logic [KEY_W-1:0]            key;
      logic [PROCESS_HANDLE_W-1:0] handle;
      logic [OCC_W-1:0]            occupancy;
   } queue_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [CMD_W-1:0]            req_cmd = CMD_INSERT;
   logic [KEY_W-1:0]            req_arrival_key = '0;
   logic [PROCESS_HANDLE_W-1:0] req_process_handle = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [STATUS_W-1:0]         rsp_status;
   logic [KEY_W-1:0]            rsp_popped_key;
   logic [PROCESS_HANDLE_W-1:0] rsp_popped_handle;
   logic [OCC_W-1:0]            rsp_occupancy;

   queue_op_type     op_backlog[$];
   queue_result_type awaited_responses[$];

   // Shadow of the entry store; slot 0 is the head.
   logic [KEY_W-1:0]            held_keys[CAPACITY];
   logic [PROCESS_HANDLE_W-1:0] held_handles[CAPACITY];
   int                          held_count = 0;

   bit req_taken = 1'b0;
   int gap_count = 0;
   int stall_count = 0;
   bit rsp_calm = 1'b0;
   int cycle_count = 0;
   int error_count = 0;
   int response_count = 0;
   int insert_count = 0, push_count = 0, pop_count = 0;
   int full_drops = 0, empty_pops = 0, unknown_cmds = 0;
   int peak_occupancy = 0, drain_pauses = 0;

   arrival_ordered_process_queue #(
      .CAPACITY    (CAPACITY),
      .HANDLE_BITS (HANDLE_BITS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_arrival_key    (req_arrival_key),
      .req_process_handle (req_process_handle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_popped_key     (rsp_popped_key),
      .rsp_popped_handle  (rsp_popped_handle),
      .rsp_occupancy      (rsp_occupancy)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one operation to the shadow store and returns the response word.
   function automatic queue_result_type apply_queue_op(
      cmd_type cmd, logic [KEY_W-1:0] key, logic [PROCESS_HANDLE_W-1:0] handle);
      queue_result_type r;
      int pos;
      r.status = STATUS_DONE;
      r.key    = '0;
      r.handle = '0;
      if (cmd == CMD_INSERT || cmd == CMD_PUSH) begin
         if (held_count >= CAPACITY) begin
            r.status = STATUS_FULL;
            full_drops++;
         end else begin
            pos = held_count;
            if (cmd == CMD_INSERT) begin
               // The new entry goes in front of the first strictly larger key.
               for (int i = held_count - 1; i >= 0; i--)
                  if (held_keys[i] > key) pos = i;
               insert_count++;
            end else begin
               push_count++;
            end
            for (int i = held_count; i > pos; i--) begin
               held_keys[i]    = held_keys[i-1];
               held_handles[i] = held_handles[i-1];
            end
            held_keys[pos]    = key;
            held_handles[pos] = handle & HANDLE_MASK;
            held_count++;
            if (held_count > peak_occupancy) peak_occupancy = held_count;
         end
      end else if (cmd == CMD_POP) begin
         if (held_count == 0) begin
            r.status = STATUS_EMPTY;
            empty_pops++;
         end else begin
            r.key    = held_keys[0];
            r.handle = held_handles[0];
            for (int i = 1; i < held_count; i++) begin
               held_keys[i-1]    = held_keys[i];
               held_handles[i-1] = held_handles[i];
            end
            held_count--;
            pop_count++;
         end
      end else begin
         unknown_cmds++;
      end
      r.occupancy = OCC_W'(held_count);
      return r;
   endfunction

   task automatic add_op(cmd_type cmd, logic [KEY_W-1:0] key,
                         logic [PROCESS_HANDLE_W-1:0] handle, int gap);
      queue_op_type op;
      op.cmd = cmd;
      op.key = key;
      op.handle = handle;
      op.gap = gap;
      op.hold_until_drained = 1'b0;
      op_backlog.push_back(op);
   endtask

   task automatic add_drain_pause();
      queue_op_type op;
      op.cmd = CMD_INSERT;
      op.key = '0;
      op.handle = '0;
      op.gap = 0;
      op.hold_until_drained = 1'b1;
      op_backlog.push_back(op);
   endtask

   // Small keys make ties common; extremes and full-width keys cover the range.
   function automatic logic [KEY_W-1:0] draw_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return KEY_W'($urandom_range(0, 15));
      if (roll < 45) return '0;
      if (roll < 50) return '1;
      return $urandom;
   endfunction

   function automatic logic [PROCESS_HANDLE_W-1:0] draw_handle();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return PROCESS_HANDLE_W'($urandom_range(0, 65535));
   endfunction

   // Sampling: predictions on accepted requests, checks on accepted responses.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still awaited",
                  cycle_count, awaited_responses.size());
         $display("FAILED: results differ");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            response_count++;
            stall_count = $urandom_range(0, rsp_calm ? 0 : 4);
            if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
            if (awaited_responses.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("response word with nothing awaited: ",
                           "status %0d key %h handle %h occ %0d",
                           rsp_status, rsp_popped_key, rsp_popped_handle,
                           rsp_occupancy);
            end else begin
               queue_result_type want;
               want = awaited_responses.pop_front();
               if (rsp_status !== want.status || rsp_popped_key !== want.key ||
                   rsp_popped_handle !== want.handle ||
                   rsp_occupancy !== want.occupancy) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch at response %0d: ", response_count,
                              "expected status %0d key %h handle %h occ %0d, ",
                              want.status, want.key, want.handle, want.occupancy,
                              "got status %0d key %h handle %h occ %0d",
                              rsp_status, rsp_popped_key, rsp_popped_handle,
                              rsp_occupancy);
               end
            end
         end
         if (req_valid && req_ready) begin
            awaited_responses.push_back(apply_queue_op(req_cmd, req_arrival_key,
                                                       req_process_handle));
            req_taken = 1'b1;
         end
      end
   end

   // Request driver.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // Word still waiting for the handshake: hold it.
      end else begin
         req_taken = 1'b0;
         if (op_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else if (op_backlog[0].hold_until_drained) begin
            req_valid <= 1'b0;
            if (awaited_responses.size() == 0) begin
               void'(op_backlog.pop_front());
               drain_pauses++;
            end
         end else if (gap_count < op_backlog[0].gap) begin
            gap_count++;
            req_valid <= 1'b0;
         end else begin
            queue_op_type op;
            op = op_backlog.pop_front();
            gap_count = 0;
            req_valid          <= 1'b1;
            req_cmd            <= op.cmd;
            req_arrival_key    <= op.key;
            req_process_handle <= op.handle;
         end
      end
   end

   // Response side back-pressure.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_count > 0) begin
         stall_count--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      int random_ops;
      int seg_len;
      int gap_max;
      int roll;
      segment_kind_type seg_kind;
      cmd_type cmd;

      // Directed: empty pop, key and handle extremes, ties, out-of-order push,
      // unknown command, then drain to empty and pop once more.
      add_op(CMD_POP,    '0,           '0,       0);
      add_op(CMD_INSERT, '1,           '1,       0);
      add_op(CMD_INSERT, '0,           '0,       1);
      add_op(CMD_INSERT, 32'd5,        16'h0001, 0);
      add_op(CMD_INSERT, 32'd5,        16'h0002, 0);
      add_op(CMD_INSERT, 32'd5,        16'h0003, 2);
      add_op(CMD_PUSH,   32'd1,        16'hA5A5, 0);
      add_op(CMD_INSERT, 32'd3,        16'h5A5A, 0);
      add_op(CMD_UNUSED, 32'hDEADBEEF, 16'hBEEF, 0);
      add_op(CMD_PUSH,   32'h80000000, 16'h8000, 3);
      for (int i = 0; i < 9; i++)
         add_op(CMD_POP, $urandom, PROCESS_HANDLE_W'($urandom_range(0, 65535)), i % 3);
      add_drain_pause();

      random_ops = 0;
      while (random_ops < RANDOM_OPS) begin
         seg_len  = $urandom_range(10, 60);
         seg_kind = segment_kind_type'($urandom_range(0, 2));
         gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 4;
         for (int i = 0; i < seg_len; i++) begin
            roll = $urandom_range(0, 99);
            if (random_ops == 0 || (random_ops < 20 && i < 20)) begin
               // Opening burst fills the store past capacity with no pops.
               cmd = (roll < 50) ? CMD_INSERT : CMD_PUSH;
            end else begin
               case (seg_kind)
                  SEG_FILL: begin
                     cmd = (roll < 3) ? CMD_UNUSED : (roll < 15) ? CMD_POP :
                           (roll < 65) ? CMD_INSERT : CMD_PUSH;
                  end
                  SEG_DRAIN: begin
                     cmd = (roll < 3) ? CMD_UNUSED : (roll < 75) ? CMD_POP :
                           (roll < 90) ? CMD_INSERT : CMD_PUSH;
                  end
                  default: begin
                     cmd = (roll < 4) ? CMD_UNUSED : (roll < 40) ? CMD_POP :
                           (roll < 75) ? CMD_INSERT : CMD_PUSH;
                  end
               endcase
            end
            add_op(cmd, draw_key(), draw_handle(), $urandom_range(0, gap_max));
            if (cmd != CMD_UNUSED) random_ops++;
         end
         if ($urandom_range(0, 5) == 0) add_drain_pause();
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (op_backlog.size() != 0 || req_valid) @(posedge clock);
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (awaited_responses.size() != 0) begin
         error_count++;
         $display("%0d response words never arrived", awaited_responses.size());
      end
      $display("covered %0d inserts, %0d pushes, %0d pops, ",
               insert_count, push_count, pop_count,
               "%0d full drops, %0d empty pops, %0d unknown commands",
               full_drops, empty_pops, unknown_cmds);
      $display("peak occupancy %0d, %0d pauses for an empty pipeline, ",
               peak_occupancy, drain_pauses,
               "%0d response words checked, %0d errors",
               response_count, error_count);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
